// ----- sv/latency_budget_monitor_macros.svh -----
// Assertion macros for the latency budget monitor checker.
// Uses the clk and rst_n names of the module that includes it.
`ifndef LATENCY_BUDGET_MONITOR_MACROS_SVH
`define LATENCY_BUDGET_MONITOR_MACROS_SVH

// same-cycle implication
`define LBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbm: same-cycle check failed");

// next-cycle implication
`define LBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbm: next-cycle check failed");

`endif

// ----- sv/lbm_pkg.sv -----
// Shared constants, types and helper functions of the latency budget monitor.
// No dependencies.
`timescale 1ns / 1ps

package lbm_pkg;

  localparam int CATEGORIES = 8;
  localparam int WINDOW     = 64;

  localparam int CAT_W   = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int WIN_W   = $clog2(WINDOW);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int ADDR_W  = $clog2(CATEGORIES * WINDOW);
  localparam int SDEPTH  = 2 ** (ADDR_W + 1);
  localparam int TIME_W  = 24;
  localparam int VIOL_W  = 32;
  localparam int MEAN_W  = 32;
  localparam int CNT_W   = 7;
  localparam int ACC_W   = MEAN_W + CNT_W + 1;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0]  WEIGHT_CAP  = 7'd100;
  localparam logic [TIME_W-1:0] COPY_BUDGET = 24'd256;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_SPIKE  = 3'd1;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [NUM_REGS-1:0][TIME_W-1:0] regs_t;

  localparam regs_t REG_RESET = {24'd512, 24'd1024, 24'd1024, 24'd256,
                                 24'd512, 24'd512, 24'd8533, 24'd4267};

  typedef struct packed {
    logic capture;
    logic rd_old;
    logic take_old;
    logic proc;
    logic tail;
    logic wr_mean;
    logic sel_p;
    logic sel_f;
    logic cap_f;
    logic load_out;
  } lbm_cmd_t;

  typedef struct packed {
    logic merge_end;
    logic proc_adv;
    logic div_done;
    logic out_free;
  } lbm_stat_t;

  // fold a category code into range by repeated subtraction
  function automatic logic [CAT_W-1:0] fold_cat(input logic [2:0] c);
    logic [4:0] v;
    v = {2'b00, c};
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'(CATEGORIES)) v = v - 5'(CATEGORIES);
    end
    return v[CAT_W-1:0];
  endfunction

  function automatic time_t budget_of(input logic [CAT_W-1:0] c, input regs_t r);
    logic [4:0] cc;
    cc = 5'(c);
    if (cc == 5'd0) return r[REG_FRAME_TARGET];
    else if (cc <= 5'd6) return r[3'(cc) + 3'd1];
    else if (cc == 5'd7) return COPY_BUDGET;
    else return r[REG_FRAME_TARGET];
  endfunction

  // floor(n*0.95) = n - ceil(n/20); n/20 by reciprocal 3277/65536
  function automatic logic [WIN_W-1:0] p95_rank(input logic [FILL_W-1:0] n);
    logic [31:0] m;
    logic [31:0] q;
    m = 32'(n) + 32'd19;
    q = (m * 32'd3277) >> 16;
    return WIN_W'(32'(n) - q);
  endfunction

endpackage

// ----- sv/latency_budget_monitor.sv -----
// Top level of the latency budget monitor: controller plus datapath.
// Depends on lbm_pkg, lbm_ctrl, lbm_datapath.
//
// Input stream: one timing request per transfer, category in in_tuser, duration
// (1/256 ms) in in_tdata. Output stream: one result per request with average,
// peak, violation count and 95th percentile in out_tdata, flags in out_tuser.
// Config: cfg_we/cfg_index/cfg_wdata write the eight 24-bit budget registers;
// write only while no request is in flight.
// From acceptance to the result load, each request walks the sorted window of its
// category, which holds the samples before the request (up to a full 64-entry
// window); the merge visits each memory entry in a fetch state and then a process
// state, and the 40-step divider for the average runs alongside it. One request
// is in work at a time; the next is accepted once the result sits in the output
// register. Reset clears all statistics and restores the budget registers; window
// memory needs no clearing. A stalled receiver holds the result; a new request may
// enter and waits at its end until the output register frees.
`timescale 1ns / 1ps

module latency_budget_monitor (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [23:0] duration
  input  logic [2:0]   in_tuser,   // [2:0] category
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] average_time, [47:24] peak_time, [79:48] violations, [103:80] percentile_95
  output logic [103:0] out_tdata,
  // [2:0] category_echo, [3] sample_over, [4] within_budget, [5] frame_gates_pass
  output logic [5:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);
  import lbm_pkg::*;

  lbm_cmd_t  cmd;
  lbm_stat_t stat;

  lbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_category (in_tuser),
    .in_duration (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ----- sv/lbm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on lbm_pkg.
`timescale 1ns / 1ps

module lbm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbm_pkg::ACC_W-1:0]   dividend,
  input  logic [lbm_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [lbm_pkg::MEAN_W-1:0]  quotient
);
  import lbm_pkg::*;

  localparam int STEP_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  always_comb begin
    trial   = {rem_r, quo_r[ACC_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
    quo_nxt = {quo_r[ACC_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= STEP_W'(ACC_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[MEAN_W-1:0];

endmodule

// ----- sv/lbm_datapath.sv -----
// Datapath: per-category statistics, sample window and sorted window memories,
// sorted-list merge, config registers and output register. Depends on lbm_pkg, lbm_div.
`timescale 1ns / 1ps

module lbm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lbm_pkg::lbm_cmd_t            cmd,
  output lbm_pkg::lbm_stat_t           stat,
  input  logic [2:0]                   in_category,
  input  logic [lbm_pkg::TIME_W-1:0]   in_duration,
  input  logic                         cfg_we,
  input  logic [lbm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lbm_pkg::TIME_W-1:0]   cfg_wdata,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [103:0]                 out_tdata,
  output logic [5:0]                   out_tuser
);
  import lbm_pkg::*;

  regs_t cfg_r;

  logic [FILL_W-1:0] fill_r [CATEGORIES];
  logic [WIN_W-1:0]  head_r [CATEGORIES];
  logic [CNT_W-1:0]  cnt_r  [CATEGORIES];
  logic [MEAN_W-1:0] mean_r [CATEGORIES];
  time_t             peak_r [CATEGORIES];
  logic [VIOL_W-1:0] viol_r [CATEGORIES];
  logic              bank_r [CATEGORIES];

  time_t wmem [CATEGORIES*WINDOW];
  time_t smem [SDEPTH];

  logic [CAT_W-1:0]  cat_r;
  time_t             dur_r, old_r, wrd_r, srd_r, p95_r, fp95_r;
  logic [CNT_W-1:0]  n_r;
  logic [ACC_W-1:0]  prod_r;
  logic [WIN_W-1:0]  wslot_r;
  logic [FILL_W-1:0] rd_r, wr_r;
  logic              removed_r, inserted_r, over_r;

  logic              out_valid_r;
  logic [103:0]      out_data_r;
  logic [5:0]        out_user_r;

  logic [FILL_W-1:0] fill_c;
  logic              full_c;
  logic [WIN_W-1:0]  slot_c;
  logic [CNT_W-1:0]  n_c;
  logic [MEAN_W+CNT_W-1:0] prod_c;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W:0]   raddr, swaddr;
  logic              swe;
  time_t             swdata, budget;
  logic              skip, ins;
  logic              div_done;
  logic [MEAN_W-1:0] quotient;
  logic              avg_ok, gates;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CAT_W-1:0] c,
                                                input logic [WIN_W-1:0] i);
    return ADDR_W'(c) * ADDR_W'(WINDOW) + ADDR_W'(i);
  endfunction

  always_comb begin
    fill_c = fill_r[cat_r];
    full_c = fill_c == FILL_W'(WINDOW);
    slot_c = full_c ? head_r[cat_r] : fill_c[WIN_W-1:0];
    n_c    = (cnt_r[cat_r] < WEIGHT_CAP) ? cnt_r[cat_r] + 1'b1 : cnt_r[cat_r];
    prod_c = mean_r[cat_r] * (n_c - 1'b1);
    waddr  = addr_of(cat_r, cmd.take_old ? wslot_r : slot_c);
    budget = budget_of(cat_r, cfg_r);

    // merge step on the current sorted entry
    skip = !removed_r && (srd_r == old_r);
    ins  = !skip && !inserted_r && (dur_r <= srd_r);

    if (cmd.sel_p)      raddr = {bank_r[cat_r], addr_of(cat_r, p95_rank(fill_c))};
    else if (cmd.sel_f) raddr = {bank_r[0], addr_of('0, p95_rank(fill_r[0]))};
    else                raddr = {bank_r[cat_r], addr_of(cat_r, rd_r[WIN_W-1:0])};

    swaddr = {!bank_r[cat_r], addr_of(cat_r, wr_r[WIN_W-1:0])};
    swe    = (cmd.proc && !skip) || (cmd.tail && !inserted_r);
    swdata = (cmd.tail || ins) ? dur_r : srd_r;

    avg_ok = mean_r[cat_r] <= {budget, 8'd0};
    gates  = (fp95_r <= cfg_r[REG_FRAME_SPIKE]) &&
             (mean_r[0] <= {cfg_r[REG_FRAME_TARGET], 8'd0});

    stat.merge_end = rd_r == fill_c;
    stat.proc_adv  = !ins;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || out_tready;
  end

  lbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.take_old),
    .dividend (ACC_W'(prod_r) + (ACC_W'(dur_r) << 8)),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_old) wmem[waddr] <= dur_r;
    wrd_r <= wmem[waddr];
    if (swe) smem[swaddr] <= swdata;
    srd_r <= smem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cat_r <= fold_cat(in_category);
      dur_r <= in_duration;
    end
    if (cmd.rd_old) begin
      n_r        <= n_c;
      prod_r     <= ACC_W'(prod_c);
      wslot_r    <= slot_c;
      rd_r       <= '0;
      wr_r       <= '0;
      removed_r  <= !full_c;
      inserted_r <= 1'b0;
      over_r     <= dur_r > budget;
    end
    if (cmd.take_old) old_r <= wrd_r;
    if (cmd.proc) begin
      if (skip) removed_r <= 1'b1;
      if (ins) inserted_r <= 1'b1;
      if (!ins) rd_r <= rd_r + 1'b1;
      if (!skip) wr_r <= wr_r + 1'b1;
    end
    if (cmd.sel_f) p95_r <= srd_r;
    if (cmd.cap_f) fp95_r <= (fill_r[0] == '0) ? '0 : srd_r;
    if (cmd.load_out) begin
      out_data_r <= {p95_r, viol_r[cat_r], peak_r[cat_r], mean_r[cat_r][31:8]};
      out_user_r <= {gates, avg_ok, over_r, 3'(cat_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= REG_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CATEGORIES; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        mean_r[i] <= '0;
        peak_r[i] <= '0;
        viol_r[i] <= '0;
        bank_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we && (4'(cfg_index) < 4'(NUM_REGS))) cfg_r[cfg_index] <= cfg_wdata;
      if (cmd.tail) begin
        if (full_c) begin
          head_r[cat_r] <= (head_r[cat_r] == WIN_W'(WINDOW - 1)) ? '0
                           : head_r[cat_r] + 1'b1;
        end else begin
          fill_r[cat_r] <= fill_c + 1'b1;
        end
        bank_r[cat_r] <= !bank_r[cat_r];
        cnt_r[cat_r]  <= n_r;
        if (dur_r > peak_r[cat_r]) peak_r[cat_r] <= dur_r;
        if (over_r && (viol_r[cat_r] != '1)) viol_r[cat_r] <= viol_r[cat_r] + 1'b1;
      end
      if (cmd.wr_mean) mean_r[cat_r] <= quotient;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- sv/lbm_ctrl.sv -----
// Controller state machine: sequences window update, sorted merge, divide,
// percentile reads and result load. Depends on lbm_pkg.
`timescale 1ns / 1ps

module lbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lbm_pkg::lbm_stat_t  stat,
  output lbm_pkg::lbm_cmd_t   cmd
);
  import lbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OLD_RD, S_OLD_TAKE, S_FETCH, S_PROC, S_TAIL,
    S_WDIV, S_RD_P, S_RD_F, S_RD_F2, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_OLD_RD;
      end
      S_OLD_RD: begin
        cmd.rd_old = 1'b1;
        state_nxt  = S_OLD_TAKE;
      end
      S_OLD_TAKE: begin
        cmd.take_old = 1'b1;
        state_nxt    = S_FETCH;
      end
      S_FETCH: state_nxt = stat.merge_end ? S_TAIL : S_PROC;
      S_PROC: begin
        cmd.proc = 1'b1;
        if (stat.proc_adv) state_nxt = S_FETCH;
      end
      S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = S_WDIV;
      end
      S_WDIV: begin
        cmd.wr_mean = stat.div_done;
        if (stat.div_done) state_nxt = S_RD_P;
      end
      S_RD_P: begin
        cmd.sel_p = 1'b1;
        state_nxt = S_RD_F;
      end
      S_RD_F: begin
        cmd.sel_f = 1'b1;
        state_nxt = S_RD_F2;
      end
      S_RD_F2: begin
        cmd.cap_f = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_tready = state_r == S_IDLE;

endmodule

// ----- sv/lbm_checker.sv -----
// Port-level checker for the latency budget monitor, bound to the top level.
// Depends on latency_budget_monitor_macros.svh.
`timescale 1ns / 1ps
`include "latency_budget_monitor_macros.svh"

module lbm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [5:0]   out_tuser
);

  // a result stays offered until taken
  `LBM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // one request in work at a time
  `LBM_ASSERT_NXT(a_one_inflight, in_tvalid && in_tready, !in_tready)
  // an over-budget sample is always counted
  `LBM_ASSERT_IMP(a_over_counted, out_tvalid && out_tuser[3], out_tdata[79:48] != 32'd0)
  // average and percentile never exceed the peak
  `LBM_ASSERT_IMP(a_peak_bound, out_tvalid,
                  (out_tdata[23:0] <= out_tdata[47:24]) &&
                  (out_tdata[103:80] <= out_tdata[47:24]))

endmodule

bind latency_budget_monitor lbm_checker u_lbm_checker (.*);

// ----- bench/latency_budget_monitor_tb.sv -----
// Self-checking bench for latency_budget_monitor: timing requests are driven on
// the input stream and each result is checked against an in-bench statistics model.
// Depends on lbm_pkg and the latency_budget_monitor RTL.
`timescale 1ns / 1ps

module latency_budget_monitor_tb;
  import lbm_pkg::*;

  typedef struct packed {
    logic [2:0]  cat;
    logic [23:0] dur;
  } sample_t;

  typedef struct packed {
    logic [2:0]  cat;
    logic [23:0] avg;
    logic [23:0] peak;
    logic [31:0] viol;
    logic [23:0] p95;
    logic        over;
    logic        avg_ok;
    logic        gates;
  } stats_t;

  localparam int WATCHDOG    = 20000;
  localparam int HOLD_CYCLES = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [5:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  latency_budget_monitor dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [23:0] m_limit [8];
  logic [23:0] m_win [8][WINDOW];
  int unsigned m_head [8];
  int unsigned m_fill [8];
  int unsigned m_wcnt [8];
  logic [31:0] m_mean [8];
  logic [23:0] m_peak [8];
  logic [31:0] m_viol [8];

  sample_t pending_q[$];
  stats_t  expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_out = 1'b0;

  function automatic logic [23:0] budget_for(input int c);
    if (c == 0) return m_limit[REG_FRAME_TARGET];
    if (c <= 6) return m_limit[c + 1];
    return 24'd256;
  endfunction

  function automatic logic [23:0] window_p95(input int c);
    int n, k, less, leq;
    logic [23:0] v;
    n = m_fill[c];
    if (n == 0) return '0;
    k = (n * 95) / 100;
    if (k >= n) k = n - 1;
    for (int i = 0; i < n; i++) begin
      v = m_win[c][i];
      less = 0;
      leq = 0;
      for (int j = 0; j < n; j++) begin
        if (m_win[c][j] < v) less++;
        if (m_win[c][j] <= v) leq++;
      end
      if (less <= k && k < leq) return v;
    end
    return '0;
  endfunction

  function automatic stats_t update_stats(input sample_t s);
    stats_t r;
    int c;
    logic [63:0] acc;
    logic [23:0] bud;
    c = s.cat;
    bud = budget_for(c);
    if (m_fill[c] < WINDOW) begin
      m_win[c][m_fill[c]] = s.dur;
      m_fill[c]++;
    end else begin
      m_win[c][m_head[c]] = s.dur;
      m_head[c] = (m_head[c] + 1) % WINDOW;
    end
    if (m_wcnt[c] < 100) m_wcnt[c]++;
    acc = 64'(m_mean[c]) * 64'(m_wcnt[c] - 1) + (64'(s.dur) << 8);
    m_mean[c] = 32'(acc / 64'(m_wcnt[c]));
    if (s.dur > m_peak[c]) m_peak[c] = s.dur;
    r.over = s.dur > bud;
    if (r.over && m_viol[c] != 32'hFFFF_FFFF) m_viol[c]++;
    r.cat = s.cat;
    r.avg = m_mean[c][31:8];
    r.peak = m_peak[c];
    r.viol = m_viol[c];
    r.p95 = window_p95(c);
    r.avg_ok = 64'(m_mean[c]) <= (64'(bud) << 8);
    r.gates = !(window_p95(0) > m_limit[REG_FRAME_SPIKE]) &&
              !(64'(m_mean[0]) > (64'(m_limit[REG_FRAME_TARGET]) << 8));
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
    return $urandom_range(0, 3);
  endfunction

  // handshake seen at the last rising edge
  bit in_tready_seen = 1'b0;
  always @(posedge clk) in_tready_seen <= in_tvalid && in_tready;

  // driver: a request holds until taken, then an optional gap
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_tready_seen)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_q[0].cat;
        in_tdata <= pending_q[0].dur;
        expected_q.insert(expected_q.size(), update_stats(pending_q.pop_front()));
        in_gap = gap_len();
      end else in_tvalid <= 1'b0;
    end
  end

  // receiver stall and monitor
  int out_gap = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_out && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt++;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      out_gap = gap_len();
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    stats_t got, exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("latency_budget_monitor_tb failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got.cat = out_tuser[2:0];
        got.over = out_tuser[3];
        got.avg_ok = out_tuser[4];
        got.gates = out_tuser[5];
        got.avg = out_tdata[23:0];
        got.peak = out_tdata[47:24];
        got.viol = out_tdata[79:48];
        got.p95 = out_tdata[103:80];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_limit(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_limit[idx] = val;
  endtask

  function automatic logic [23:0] rand_dur(input int c, input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'(budget_for(c) + $urandom_range(0, 2) - 1);
      default: return 24'($urandom_range(0, 1200));
    endcase
  endfunction

  task automatic add_random(input int count, input int mode);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      s.cat = 3'($urandom_range(0, 7));
      s.dur = rand_dur(s.cat, $urandom_range(0, 9) == 0 ? 0 : mode);
      pending_q.insert(pending_q.size(), s);
    end
  endtask

  initial begin
    sample_t s;
    for (int i = 0; i < 8; i++) begin
      m_limit[i] = REG_RESET[i];
      m_head[i] = 0; m_fill[i] = 0; m_wcnt[i] = 0;
      m_mean[i] = '0; m_peak[i] = '0; m_viol[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty frame window, extremes, every category, budget edges
    for (int c = 7; c >= 0; c--) begin
      s.cat = 3'(c); s.dur = 24'hFFFFFF; pending_q.insert(pending_q.size(), s);
      s.dur = 24'd0; pending_q.insert(pending_q.size(), s);
    end
    for (int c = 0; c < 8; c++) begin
      s.cat = 3'(c); s.dur = budget_for(c); pending_q.insert(pending_q.size(), s);
    end
    wait_drained();

    // fill the block while the receiver holds off
    hold_out = 1'b1;
    add_random(6, 2);
    wait_drained();
    hold_out = 1'b0;

    // zero limits: every nonzero sample outside category 7 is above budget
    for (int i = 0; i < 8; i++) write_limit(3'(i), 24'd0);
    add_random(100, 2);
    wait_drained();

    // max limits: nothing outside category 7 is above budget
    for (int i = 0; i < 8; i++) write_limit(3'(i), 24'hFFFFFF);
    add_random(100, 0);
    wait_drained();

    // random limits, mostly near typical samples
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 8; i++)
        write_limit(3'(i), r == 2 ? 24'($urandom) : 24'($urandom_range(0, 1200)));
      add_random(100, 1);
      wait_drained();
    end

    if (errors == 0) $display("latency_budget_monitor_tb passed");
    else $display("latency_budget_monitor_tb failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/lbm_pkg.sv
sv/lbm_div.sv
sv/lbm_datapath.sv
sv/lbm_ctrl.sv
sv/latency_budget_monitor.sv
sv/lbm_checker.sv
bench/latency_budget_monitor_tb.sv
